>>> rtl/shs_pkg.sv
// Package for the SHA-256 stream hasher: constants, round table, control types.
package shs_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned LenBits   = 61;

  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] FillLen  = 6'd56;
  localparam logic [5:0] RndLast  = 6'd63;
  localparam logic [1:0] WordLast = 2'd3;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [7:0] PadZero = 8'h00;

  typedef logic [7:0][31:0] word_vec_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO
  } byte_src_t;

  typedef struct packed {
    logic      in_ready;
    logic      shift_en;
    byte_src_t shift_src;
    logic      count_en;
    logic      len_load;
    logic      vars_load;
    logic      round_en;
    logic [5:0] rnd;
    logic      fold;
    logic      out_valid;
    logic [1:0] out_index;
    logic      restart;
  } ctl_t;

endpackage

>>> rtl/shs_in_if.sv
// Input channel interface: one message byte item per handshake.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input end_of_message,
                output ready);
endinterface

>>> rtl/shs_out_if.sv
// Output channel interface: one 64-bit digest word item per handshake.
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

>>> rtl/sha256_stream_hasher_core.sv
// Top level of the byte-serial SHA-256 stream hasher.
//
// The msg channel takes one item per handshake: an optional message byte
// (has_byte) and an end_of_message flag. Bytes pack big-endian into a
// 64-byte block held in a 512-bit shift register that also serves as the
// 16-word message schedule window during compression.
// Byte items are taken one per cycle while msg.ready is high. When a block
// fills, msg.ready drops while it compresses: 64 rounds through the single
// shared round unit, one per cycle, then a fold step that adds the working
// variables into the hash state.
// On end_of_message the sequencer shifts in 0x80 and zero bytes one per
// cycle up to byte 56 (compressing an extra block when the message leaves
// 56 or more bytes in the last block), loads the 64-bit bit length, and
// compresses once more. The digest channel then presents four 64-bit words,
// most significant first, word_index 0 to 3, last_word on the fourth.
// While the receiver stalls, the current word holds and no input is taken.
// After the fourth word is accepted the hash state returns to the initial
// value and byte count to zero, exactly as after reset (rst, synchronous).
module sha256_stream_hasher_core (
  input logic       clk,
  input logic       rst,
  shs_in_if.sink    msg,
  shs_out_if.source digest
);

  shs_pkg::ctl_t       ctl;
  shs_pkg::word_vec_t  vars;
  shs_pkg::word_vec_t  vars_next;
  logic [shs_pkg::BlockBits-1:0] blk;
  logic [31:0]         hs [8];
  logic [shs_pkg::LenBits-1:0] byte_count;
  logic [31:0]         w_new;
  logic [7:0]          shift_byte;
  logic [2:0]          hi_sel;
  logic [2:0]          lo_sel;

  shs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (msg.valid),
    .has_byte       (msg.has_byte),
    .end_of_message (msg.end_of_message),
    .out_ready      (digest.ready),
    .ctl            (ctl)
  );

  // Schedule taps: word 0 is the word consumed by the current round.
  shs_round u_round (
    .v      (vars),
    .k      (shs_pkg::ROUND_K[ctl.rnd]),
    .w0     (blk[511:480]),
    .w1     (blk[479:448]),
    .w9     (blk[223:192]),
    .w14    (blk[63:32]),
    .v_next (vars_next),
    .w_new  (w_new)
  );

  always_comb begin
    unique case (ctl.shift_src)
      shs_pkg::SRC_DATA: shift_byte = msg.data_byte;
      shs_pkg::SRC_MARK: shift_byte = shs_pkg::PadMark;
      shs_pkg::SRC_ZERO: shift_byte = shs_pkg::PadZero;
      default:           shift_byte = shs_pkg::PadZero;
    endcase
  end

  // Block buffer and schedule window; no reset, every byte is written
  // before the block is compressed. The buffer holds when nothing shifts.
  always_ff @(posedge clk) begin
    if (ctl.round_en) begin
      blk <= {blk[479:0], w_new};
    end else if (ctl.len_load) begin
      blk <= {blk[447:0], byte_count, 3'b000};
    end else if (ctl.shift_en) begin
      blk <= {blk[503:0], shift_byte};
    end
  end

  // Working variables a..h.
  always_ff @(posedge clk) begin
    if (ctl.vars_load) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= hs[i];
      end
    end else if (ctl.round_en) begin
      vars <= vars_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      for (int i = 0; i < 8; i++) begin
        hs[i] <= shs_pkg::IV[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hs[i] <= hs[i] + vars[i];
      end
    end
  end

  // Message length in bytes, wrapping modulo 2^61.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      byte_count <= '0;
    end else if (ctl.count_en) begin
      byte_count <= byte_count + {{(shs_pkg::LenBits-1){1'b0}}, 1'b1};
    end
  end

  assign hi_sel = {ctl.out_index, 1'b0};
  assign lo_sel = {ctl.out_index, 1'b1};

  assign msg.ready          = ctl.in_ready;
  assign digest.valid       = ctl.out_valid;
  assign digest.digest_word = {hs[hi_sel], hs[lo_sel]};
  assign digest.word_index  = ctl.out_index;
  assign digest.last_word   = ctl.out_index == shs_pkg::WordLast;

`ifndef SYNTHESIS
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !msg.ready)
    else $error("input accepted while digest pending");
  a_restart_iv: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=>
      (hs[0] == shs_pkg::IV[0] && hs[7] == shs_pkg::IV[7] && byte_count == '0))
    else $error("hash state not restarted after digest");
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && digest.word_index == $past(digest.word_index) + 2'd1))
    else $error("digest words out of order");
`endif

endmodule

>>> rtl/shs_round.sv
// One SHA-256 compression round and one message schedule step.
module shs_round (
  input  shs_pkg::word_vec_t v,
  input  logic [31:0]        k,
  input  logic [31:0]        w0,
  input  logic [31:0]        w1,
  input  logic [31:0]        w9,
  input  logic [31:0]        w14,
  output shs_pkg::word_vec_t v_next,
  output logic [31:0]        w_new
);

  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] small_s0;
  logic [31:0] small_s1;

  // v[0] is a, v[7] is h.
  always_comb begin
    big_s1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
             {v[4][24:0], v[4][31:25]};
    big_s0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
             {v[0][21:0], v[0][31:22]};
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_s1 + choose + k + w0;
    t2     = big_s0 + major;

    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  // The schedule word sixteen places ahead of the one consumed this round.
  always_comb begin
    small_s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    small_s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
    w_new    = w0 + small_s0 + w9 + small_s1;
  end

endmodule

>>> rtl/shs_ctrl.sv
// Sequencer: byte fill, padding, round count and digest word emission.
module shs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          has_byte,
  input  logic          end_of_message,
  input  logic          out_ready,
  output shs_pkg::ctl_t ctl
);

  shs_pkg::state_t state;
  shs_pkg::state_t state_next;
  logic [5:0] fill;
  logic [5:0] fill_next;
  logic [5:0] rnd;
  logic [5:0] rnd_next;
  logic [1:0] widx;
  logic [1:0] widx_next;
  logic       fin;
  logic       fin_next;
  logic       mark;
  logic       mark_next;
  logic       last;
  logic       last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shs_pkg::ST_IDLE;
      fill  <= 6'd0;
      rnd   <= 6'd0;
      widx  <= 2'd0;
      fin   <= 1'b0;
      mark  <= 1'b0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rnd   <= rnd_next;
      widx  <= widx_next;
      fin   <= fin_next;
      mark  <= mark_next;
      last  <= last_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    fill_next  = fill;
    rnd_next   = rnd;
    widx_next  = widx;
    fin_next   = fin;
    mark_next  = mark;
    last_next  = last;
    unique case (state)
      shs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (has_byte) begin
            fill_next = fill + 6'd1;
          end
          if (has_byte && fill == shs_pkg::FillLast) begin
            state_next = shs_pkg::ST_ROUND;
            rnd_next   = 6'd0;
            fin_next   = end_of_message;
          end else if (end_of_message) begin
            state_next = shs_pkg::ST_PAD;
            fin_next   = 1'b1;
          end
        end
      end
      shs_pkg::ST_ROUND: begin
        rnd_next = rnd + 6'd1;
        if (rnd == shs_pkg::RndLast) begin
          state_next = shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        priority if (last) begin
          state_next = shs_pkg::ST_EMIT;
          widx_next  = 2'd0;
        end else if (fin) begin
          state_next = shs_pkg::ST_PAD;
        end else begin
          state_next = shs_pkg::ST_IDLE;
        end
      end
      shs_pkg::ST_PAD: begin
        if (mark && fill == shs_pkg::FillLen) begin
          fill_next  = 6'd0;
          last_next  = 1'b1;
          state_next = shs_pkg::ST_ROUND;
          rnd_next   = 6'd0;
        end else begin
          mark_next = 1'b1;
          fill_next = fill + 6'd1;
          if (fill == shs_pkg::FillLast) begin
            state_next = shs_pkg::ST_ROUND;
            rnd_next   = 6'd0;
          end
        end
      end
      shs_pkg::ST_EMIT: begin
        if (out_ready) begin
          widx_next = widx + 2'd1;
          if (widx == shs_pkg::WordLast) begin
            state_next = shs_pkg::ST_IDLE;
            fin_next   = 1'b0;
            mark_next  = 1'b0;
            last_next  = 1'b0;
          end
        end
      end
      default: begin
        state_next = shs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctl           = '0;
    ctl.shift_src = shs_pkg::SRC_DATA;
    ctl.rnd       = rnd;
    ctl.out_index = widx;
    unique case (state)
      shs_pkg::ST_IDLE: begin
        ctl.in_ready  = 1'b1;
        ctl.shift_en  = in_valid && has_byte;
        ctl.count_en  = in_valid && has_byte;
        ctl.vars_load = in_valid && has_byte && fill == shs_pkg::FillLast;
      end
      shs_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
      end
      shs_pkg::ST_FOLD: begin
        ctl.fold = 1'b1;
      end
      shs_pkg::ST_PAD: begin
        if (mark && fill == shs_pkg::FillLen) begin
          ctl.len_load  = 1'b1;
          ctl.vars_load = 1'b1;
        end else begin
          ctl.shift_en  = 1'b1;
          ctl.shift_src = mark ? shs_pkg::SRC_ZERO : shs_pkg::SRC_MARK;
          ctl.vars_load = fill == shs_pkg::FillLast;
        end
      end
      shs_pkg::ST_EMIT: begin
        ctl.out_valid = 1'b1;
        ctl.restart   = out_ready && widx == shs_pkg::WordLast;
      end
      default: begin
        ctl.in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == shs_pkg::ST_ROUND && rnd == shs_pkg::RndLast) |=> state == shs_pkg::ST_FOLD)
    else $error("last round not followed by fold");
  a_emit_fill_clear: assert property (@(posedge clk) disable iff (rst)
    state == shs_pkg::ST_EMIT |-> fill == 6'd0)
    else $error("block buffer not empty while emitting digest");
  a_final_fold_emits: assert property (@(posedge clk) disable iff (rst)
    (state == shs_pkg::ST_FOLD && last) |=> state == shs_pkg::ST_EMIT)
    else $error("final block did not lead to digest output");
`endif

endmodule
